### sv/swm_pkg.sv
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int LEN_W    = 5;
    // Age field sized for up to 256 entries; the length field caps a window at 31.
    localparam int AGE_W    = 8;

    localparam logic [LEN_W-1:0] LEN_RESET = 5'd3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MEDIAN_W-1:0] t_median;
    typedef logic [AGE_W-1:0]           t_age;
    typedef logic [LEN_W-1:0]           t_len;

    typedef struct packed {
        t_sample sample;
        logic    last_sample;
    } t_swm_in;

    typedef struct packed {
        t_median median_doubled;
        logic    last_result;
    } t_swm_out;

    // One stored window entry.
    typedef struct packed {
        t_sample value;
        t_age    age;
    } t_swm_ent;

    // Cell k to cell k+1: eviction prefix, insert condition, compacted entry.
    typedef struct packed {
        logic     removed;
        logic     cond;
        t_swm_ent ent;
    } t_swm_fwd;

    // Cell k to cell k-1: raw entry with its occupancy and compare result.
    typedef struct packed {
        logic     occ;
        logic     gt;
        t_swm_ent ent;
    } t_swm_bwd;

    // Broadcast to every cell.
    typedef struct packed {
        logic    accept;
        logic    evict;
        t_age    old_age;
        t_sample sample;
    } t_swm_ctl;

endpackage

### sv/swm_cell.sv
module swm_cell (
    input  logic              i_clk,
    input  swm_pkg::t_swm_ctl i_ctl,
    input  logic              i_occ,
    input  swm_pkg::t_swm_fwd i_left,
    input  swm_pkg::t_swm_bwd i_right,
    output swm_pkg::t_swm_fwd o_right,
    output swm_pkg::t_swm_bwd o_left
);
    import swm_pkg::*;

    t_swm_ent r_ent;
    t_swm_ent n_ent;
    t_swm_ent w_comp;
    logic     w_rm;
    logic     w_removed;
    logic     w_gt;
    logic     w_comp_occ;
    logic     w_comp_gt;
    logic     w_cond;

    always_comb begin
        // drop this entry if it is the oldest one and the window is full
        w_rm       = i_ctl.evict && i_occ && (r_ent.age == i_ctl.old_age);
        w_removed  = i_left.removed || w_rm;
        w_gt       = i_occ && ($signed(r_ent.value) > $signed(i_ctl.sample));
        w_comp     = w_removed ? i_right.ent : r_ent;
        w_comp_occ = w_removed ? i_right.occ : i_occ;
        w_comp_gt  = w_removed ? i_right.gt : w_gt;
        w_cond     = w_comp_gt || !w_comp_occ;
    end

    always_comb begin
        if (i_left.cond) begin
            n_ent.value = i_left.ent.value;
            n_ent.age   = i_left.ent.age + 1'b1;
        end else if (w_cond) begin
            n_ent.value = i_ctl.sample;
            n_ent.age   = '0;
        end else begin
            n_ent.value = w_comp.value;
            n_ent.age   = w_comp.age + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_ent <= n_ent;
        end
    end

    assign o_right = '{removed: w_removed, cond: w_cond, ent: w_comp};
    assign o_left  = '{occ: i_occ, gt: w_gt, ent: r_ent};

endmodule

### sv/swm_out.sv
module swm_out #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic                        i_last,
    input  logic [$clog2(WINDOW_MAX)-1:0] i_lo_idx,
    input  logic [$clog2(WINDOW_MAX)-1:0] i_hi_idx,
    input  swm_pkg::t_sample            i_vals [WINDOW_MAX],
    input  logic                        i_stall,
    output logic                        o_valid,
    output swm_pkg::t_swm_out           o_data,
    output logic                        o_block
);
    import swm_pkg::*;

    logic     r_valid;
    t_swm_out r_data;
    t_sample  w_lo;
    t_sample  w_hi;
    t_median  w_sum;

    assign w_lo    = i_vals[i_lo_idx];
    assign w_hi    = i_vals[i_hi_idx];
    assign w_sum   = {w_lo[SAMPLE_W-1], w_lo} + {w_hi[SAMPLE_W-1], w_hi};
    assign o_block = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_data.median_doubled <= w_sum;
            r_data.last_result    <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/sliding_window_median_core.sv
// Channel   Direction  Handshake              Payload
// ------------------------------------------------------------------
// in        sink       i_in_valid/o_in_stall  i_in_data  (t_swm_in)
// out       source     o_out_valid/i_out_stall o_out_data (t_swm_out)
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_data (window length)
//
// One sample request per clock while the input is not stalled. The sorted
// window lives in a row of WINDOW_MAX cells that evict, compact and insert
// in the accept cycle; the median is then picked and summed into the output
// register once a held output no longer blocks it. Reset clears the fill count
// and the output valid and loads a window length of 3; cell contents are not
// reset. A stalled output holds its result; the input stalls when a finished
// median is waiting behind a held output, and for the cycle of a length write.
module sliding_window_median_core #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  swm_pkg::t_swm_in      i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output swm_pkg::t_swm_out     o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  swm_pkg::t_len         i_cfg_data
);
    import swm_pkg::*;

    localparam int FW = $clog2(WINDOW_MAX + 1);
    localparam int IW = $clog2(WINDOW_MAX);

    t_len          r_len;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic          r_pend;
    logic          n_pend;
    logic          r_pend_last;

    logic [FW-1:0] w_len;
    logic [FW-1:0] w_len_m1;
    logic [FW-1:0] w_fill_after;
    logic          w_acc;
    logic          w_cfg_wr;
    logic          w_evict;
    logic          w_produce;
    logic          w_out_block;
    logic          w_take;
    t_swm_ctl      w_ctl;

    t_swm_fwd      w_fwd [WINDOW_MAX+1];
    t_swm_bwd      w_bwd [WINDOW_MAX+1];
    t_sample       w_vals [WINDOW_MAX];

    // Clamp the programmed length to 1..WINDOW_MAX.
    always_comb begin
        if (r_len == '0) begin
            w_len = FW'(1);
        end else if (int'(r_len) > WINDOW_MAX) begin
            w_len = FW'(WINDOW_MAX);
        end else begin
            w_len = FW'(r_len);
        end
    end

    assign w_len_m1 = w_len - 1'b1;

    // Stall when a finished median cannot move into a held output, and hold
    // the sample back while a length write takes this cycle.
    assign o_in_stall  = (r_pend && w_out_block) || w_cfg_wr;
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_cfg_ready = !r_pend;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign w_take      = r_pend && !w_out_block;

    // A full window evicts its oldest entry, whose age is fill - 1.
    assign w_evict      = (r_fill == w_len);
    assign w_fill_after = w_evict ? r_fill : r_fill + 1'b1;
    assign w_produce    = (w_fill_after == w_len);

    assign w_ctl = '{accept:  w_acc,
                     evict:   w_evict,
                     old_age: AGE_W'(r_fill - 1'b1),
                     sample:  i_in_data.sample};

    always_comb begin
        n_fill = r_fill;
        if (w_cfg_wr) begin
            n_fill = '0;
        end else if (w_acc) begin
            // a last sample empties the window after its result
            n_fill = i_in_data.last_sample ? '0 : w_fill_after;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (w_acc) begin
            n_pend = w_produce;
        end else if (w_take) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_fill <= '0;
            r_pend <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_len <= i_cfg_data;
            end
            r_fill <= n_fill;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_pend_last <= i_in_data.last_sample;
        end
    end

    // Chain ends: nothing removed or larger to the left, empty slot to the right.
    assign w_fwd[0]          = '{removed: 1'b0, cond: 1'b0, ent: '0};
    assign w_bwd[WINDOW_MAX] = '{occ: 1'b0, gt: 1'b0, ent: '0};

    for (genvar k = 0; k < WINDOW_MAX; k++) begin : g_cell
        logic w_occ;
        assign w_occ     = (int'(r_fill) > k);
        assign w_vals[k] = w_bwd[k].ent.value;

        swm_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_occ   (w_occ),
            .i_left  (w_fwd[k]),
            .i_right (w_bwd[k+1]),
            .o_right (w_fwd[k+1]),
            .o_left  (w_bwd[k])
        );
    end

    swm_out #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_take),
        .i_last   (r_pend_last),
        .i_lo_idx (IW'(w_len_m1 >> 1)),
        .i_hi_idx (IW'(w_len >> 1)),
        .i_vals   (w_vals),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data),
        .o_block  (w_out_block)
    );

endmodule

### test/swm_checker.sv
module swm_checker #(
    parameter int WINDOW_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  swm_pkg::t_swm_in  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  swm_pkg::t_swm_out i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  swm_pkg::t_len     i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    import swm_pkg::*;

    t_len     win_len;
    t_sample  window_hist[$];      // samples in arrival order, oldest first
    t_swm_out pending_medians[$];  // medians still owed by the block
    int       err_count = 0;

    function automatic int eff_len(t_len v);
        if (v == '0) return 1;
        if (int'(v) > WINDOW_MAX) return WINDOW_MAX;
        return int'(v);
    endfunction

    // Sort a copy of the window and add the two middle entries at 33 bits.
    function automatic t_median window_median(int len);
        t_sample sorted[WINDOW_MAX];
        t_sample key;
        int      i;
        int      j;
        for (i = 0; i < len; i++) begin
            key = window_hist[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return {sorted[(len-1)/2][SAMPLE_W-1], sorted[(len-1)/2]}
             + {sorted[len/2][SAMPLE_W-1], sorted[len/2]};
    endfunction

    task automatic report_mismatch(string what, t_swm_out got, t_swm_out want);
        $display("MISMATCH %s: got median %0d last %0b, want median %0d last %0b",
                 what, got.median_doubled, got.last_result,
                 want.median_doubled, want.last_result);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_swm_out want;
        t_swm_out res;
        int       len;
        if (!i_rst_n) begin
            win_len = LEN_RESET;
            window_hist.delete();
            pending_medians.delete();
        end else begin
            // compare first: a result never belongs to a request of this edge
            if (i_out_valid && !i_out_stall) begin
                if (pending_medians.size() == 0) begin
                    report_mismatch("unexpected result", i_out_data, '0);
                end else begin
                    want = pending_medians.pop_front();
                    if (i_out_data.median_doubled !== want.median_doubled)
                        report_mismatch("median", i_out_data, want);
                    if (i_out_data.last_result !== want.last_result)
                        report_mismatch("last flag", i_out_data, want);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                win_len = i_cfg_data;
                window_hist.delete();
            end
            if (i_in_valid && !i_in_stall) begin
                len = eff_len(win_len);
                while (window_hist.size() >= len)
                    window_hist.delete(0);
                window_hist.push_back(i_in_data.sample);
                if (window_hist.size() == len) begin
                    res.median_doubled = window_median(len);
                    res.last_result    = i_in_data.last_sample;
                    pending_medians.push_back(res);
                end
                if (i_in_data.last_sample)
                    window_hist.delete();
            end
        end
        o_pending = pending_medians.size();
        o_errors  = err_count;
    end

endmodule

### test/tb_top.sv
module tb_top;
    import swm_pkg::*;

    localparam int      WIN_MAX    = 16;
    // Cycles without any accepted request before the run is declared hung.
    // The long receiver hold-off below is far shorter than this.
    localparam int      IDLE_LIMIT = 3000;
    localparam int      HOLD_LEN   = 150;
    // Wait after the last owed result so a trailing sample is finished too.
    localparam int      SETTLE     = 6;
    localparam int      PHASE_REQS = 55;
    localparam t_sample S_MIN      = 32'sh8000_0000;
    localparam t_sample S_MAX      = 32'sh7FFF_FFFF;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    t_swm_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    t_swm_out o_out_data;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_len     i_cfg_data;

    int       err_total;
    int       owed;
    int       idle_cycles = 0;

    // Stimulus-to-receiver flags: no random stalls while calm, one long
    // hold-off once requested.
    bit       calm      = 0;
    bit       hold_req  = 0;
    bit       hold_done = 0;

    sliding_window_median_core #(
        .WINDOW_MAX (WIN_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    swm_checker #(
        .WINDOW_MAX (WIN_MAX)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (err_total),
        .o_pending   (owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: restart the count on any accepted request, result or write.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall at random, never while calm, and hold off for one long
    // stretch so the block fills up and stalls its input.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(negedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < 18);
            end
        end
    end

    // Mix of extremes, a narrow band that makes equal values common, and
    // full-range noise.
    function automatic t_sample pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return $urandom_range(0, 1) ? t_sample'(0) : t_sample'(-1);
            3, 4, 5: return t_sample'($signed($urandom_range(0, 16)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Offer one sample request; call and return at a falling edge. Valid stays
    // high across back-to-back requests.
    task automatic send_req(t_sample s, logic last);
        t_swm_in d;
        d.sample      = s;
        d.last_sample = last;
        while (!calm && $urandom_range(0, 99) < 18) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Hold the input until every owed result is out, then let the pipeline
    // settle so a trailing no-result sample is finished too.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (owed != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_len(t_len v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int   lens[10];
        int   items;
        int   n;
        int   k;
        int   r;
        int   eff;
        logic term;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset length 3: extremes on both sides, doubled minimum and maximum.
        send_req(S_MIN, 1'b0);
        send_req(S_MIN, 1'b0);
        send_req(S_MIN, 1'b0);
        send_req(S_MAX, 1'b0);
        send_req(S_MAX, 1'b0);
        send_req(5, 1'b1);
        // Last sample on a window that is not yet full: no result.
        send_req(7, 1'b1);
        // Equal values in the window.
        send_req(-1, 1'b0);
        send_req(0, 1'b0);
        send_req(-1, 1'b0);
        send_req(3, 1'b0);
        send_req(-1, 1'b1);
        drain();

        // Length 0 acts as 1: pass-through.
        write_len(5'd0);
        send_req(-3, 1'b0);
        send_req(S_MAX, 1'b1);
        drain();

        // Even length: sum of the two middle values.
        write_len(5'd2);
        send_req(S_MIN, 1'b0);
        send_req(S_MAX, 1'b0);
        send_req(4, 1'b0);
        send_req(4, 1'b1);
        drain();

        // Random phases, one window length each, 16 and out-of-range among them.
        lens = '{5, 16, 1, 31, 2, 0, 8, 17, 4, 12};
        lens[9] = $urandom_range(3, 15);
        for (int p = 0; p < 10; p++) begin
            write_len(t_len'(lens[p]));
            eff = (lens[p] == 0) ? 1 : ((lens[p] > WIN_MAX) ? WIN_MAX : lens[p]);
            calm = (p == 1);
            if (p == 2)
                hold_req = 1;
            items = 0;
            while (items < PHASE_REQS) begin
                // Mostly sequences that fill the window and run on; some
                // short ones of at most the window length.
                r = $urandom_range(0, 99);
                if (r < 70)
                    n = eff + $urandom_range(0, 2 * eff + 4);
                else if (r < 85)
                    n = $urandom_range(1, eff);
                else
                    n = $urandom_range(1, 3 * eff);
                term = ($urandom_range(0, 99) < 80);
                for (k = 0; k < n; k++) begin
                    send_req(pick_value(),
                             (k == n - 1) ? term : ($urandom_range(0, 99) < 3));
                    items++;
                end
            end
            calm = 0;
            drain();
        end

        if (err_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
